// ----- hw/rtl/parp_pkg.sv -----
`default_nettype none

package parp_pkg;

	localparam int unsigned ROLE_W  = 3;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned AXIS_W  = 2;
	localparam int unsigned DELTA_W = 16;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned STATE_W = 9;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned DIV_BITS   = DELTA_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_BITS);

	localparam logic [KIND_W-1:0] KIND_PASS     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOTION   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WHEEL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONSUMED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TAP      = 3'd4;

	localparam logic [ROLE_W-1:0] ROLE_MOVE    = 3'd0;
	localparam logic [ROLE_W-1:0] ROLE_SCROLL  = 3'd1;
	localparam logic [ROLE_W-1:0] ROLE_OFF     = 3'd2;
	localparam logic [ROLE_W-1:0] ROLE_ENCODER = 3'd3;

	localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_OTHER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROLE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ONE,
		ST_ENC
	} state_t;

	typedef enum logic [1:0] {
		PATH_SINGLE,
		PATH_DIV,
		PATH_ENC
	} path_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic emit_tap;
		logic emit_final;
	} cmd_t;

	typedef struct packed {
		path_t path;
		logic  div_done;
		logic  tap_avail;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/parp_if.sv -----
`default_nettype none

interface parp_in_if import parp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [AXIS_W-1:0]         axis_code;
	logic signed [DELTA_W-1:0] delta;

	modport source (output valid, output axis_code, output delta, input ready);
	modport sink (input valid, input axis_code, input delta, output ready);
endinterface

interface parp_out_if import parp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [AXIS_W-1:0]         out_axis;
	logic signed [DELTA_W-1:0] out_value;
	logic                      tap_negative;
	logic                      last;

	modport source (output valid, output kind, output out_axis, output out_value,
		output tap_negative, output last, input ready);
	modport sink (input valid, input kind, input out_axis, input out_value,
		input tap_negative, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/parp_ctrl.sv -----
`default_nettype none

module parp_ctrl import parp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.path)
						PATH_DIV: state_d = ST_DIV;
						PATH_ENC: state_d = ST_ENC;
						default:  state_d = ST_ONE;
					endcase
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_ONE;
			end
			ST_ONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_ENC: begin
				if (sts.out_free && !sts.tap_avail) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_ONE: begin
				cmd.emit_final = sts.out_free;
			end
			ST_ENC: begin
				cmd.emit_tap   = sts.out_free && sts.tap_avail;
				cmd.emit_final = sts.out_free && !sts.tap_avail;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/parp_dp.sv -----
`default_nettype none

module parp_dp import parp_pkg::*; #(
	parameter int unsigned MAX_TAPS = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [AXIS_W-1:0]         in_axis_code,
	input  wire logic signed [DELTA_W-1:0] in_delta,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [KIND_W-1:0]              out_kind,
	output logic [AXIS_W-1:0]              out_axis,
	output logic signed [DELTA_W-1:0]      out_value,
	output logic                           out_tap_negative,
	output logic                           out_last,
	input  wire cmd_t                      cmd,
	output sts_t                           sts
);

	localparam int unsigned TAP_CNT_W = $clog2(MAX_TAPS + 1);
	localparam int unsigned TOT_W     = DELTA_W + 1;

	// configuration
	logic [ROLE_W-1:0] role_x_q, role_y_q;
	logic              inv_x_q, inv_y_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;

	// per-axis state
	logic signed [STATE_W-1:0] rem_x_q, rem_y_q, acc_x_q, acc_y_q;
	logic [ROLE_W-1:0]         seen_x_q, seen_y_q;

	// item registers
	logic [AXIS_W-1:0]         it_axis_q;
	logic                      it_other_q;
	logic [ROLE_W-1:0]         it_role_q;
	logic [STEP_W-1:0]         it_step_q;
	logic signed [DELTA_W-1:0] it_delta_q;
	logic signed [TOT_W-1:0]   total_q;
	logic [DIV_BITS-1:0]       div_quo_q;
	logic [STEP_W-1:0]         div_rem_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [TAP_CNT_W-1:0]      tap_cnt_q;

	logic                      out_valid_q;
	logic [KIND_W-1:0]         out_kind_q;
	logic [AXIS_W-1:0]         out_axis_q;
	logic signed [DELTA_W-1:0] out_value_q;
	logic                      out_neg_q;
	logic                      out_last_q;

	// input side decode
	logic                      is_other, is_x, inv_sel, changed;
	logic [ROLE_W-1:0]         role_sel, seen_sel;
	logic [STEP_W-1:0]         step_raw, step_eff;
	logic signed [DELTA_W-1:0] v;
	logic signed [STATE_W-1:0] old_sel;
	logic signed [TOT_W-1:0]   total_in;
	logic [TOT_W-1:0]          total_mag;
	path_t                     path;

	always_comb begin
		is_other = (in_axis_code != AXIS_X) && (in_axis_code != AXIS_Y);
		is_x     = (in_axis_code == AXIS_X);
		role_sel = is_x ? role_x_q : role_y_q;
		seen_sel = is_x ? seen_x_q : seen_y_q;
		inv_sel  = is_x ? inv_x_q : inv_y_q;
		step_raw = is_x ? step_x_q : step_y_q;
		step_eff = (step_raw == '0) ? STEP_W'(1) : step_raw;
		changed  = (seen_sel != role_sel);
		if (!inv_sel) begin
			v = in_delta;
		end else if (in_delta == {1'b1, {(DELTA_W-1){1'b0}}}) begin
			v = {1'b0, {(DELTA_W-1){1'b1}}};
		end else begin
			v = -in_delta;
		end
		if (changed) begin
			old_sel = '0;
		end else if (role_sel == ROLE_ENCODER) begin
			old_sel = is_x ? acc_x_q : acc_y_q;
		end else begin
			old_sel = is_x ? rem_x_q : rem_y_q;
		end
		total_in  = TOT_W'(v) + TOT_W'(old_sel);
		total_mag = total_in[TOT_W-1] ? TOT_W'(-total_in) : TOT_W'(total_in);
		if (is_other) begin
			path = PATH_SINGLE;
		end else if (role_sel inside {ROLE_MOVE, ROLE_SCROLL}) begin
			path = PATH_DIV;
		end else if (role_sel == ROLE_ENCODER) begin
			path = PATH_ENC;
		end else begin
			path = PATH_SINGLE;
		end
	end

	// divider step
	logic [STEP_W:0]   div_sh;
	logic              div_ge;
	logic [STEP_W-1:0] div_nxt;

	always_comb begin
		div_sh  = {div_rem_q, div_quo_q[DIV_BITS-1]};
		div_ge  = (div_sh >= {1'b0, it_step_q});
		div_nxt = div_ge ? STEP_W'(div_sh - {1'b0, it_step_q}) : div_sh[STEP_W-1:0];
	end

	// encoder compare
	logic signed [TOT_W-1:0]   step_s;
	logic                      tap_room, tap_pos, tap_neg;
	logic [STEP_W-1:0]         step_m1;
	logic signed [STATE_W-1:0] acc_fin;

	always_comb begin
		step_s   = $signed({{(TOT_W-STEP_W){1'b0}}, it_step_q});
		tap_room = (tap_cnt_q < TAP_CNT_W'(MAX_TAPS));
		tap_pos  = tap_room && (total_q >= step_s);
		tap_neg  = tap_room && (total_q <= -step_s);
		step_m1  = it_step_q - STEP_W'(1);
		if (total_q >= step_s) begin
			acc_fin = $signed({1'b0, step_m1});
		end else if (total_q <= -step_s) begin
			acc_fin = -$signed({1'b0, step_m1});
		end else begin
			acc_fin = total_q[STATE_W-1:0];
		end
	end

	// final result of the item
	logic                      q_neg;
	logic signed [DELTA_W-1:0] q_sat;
	logic signed [STATE_W-1:0] rem_fin;
	logic [KIND_W-1:0]         fin_kind;
	logic signed [DELTA_W-1:0] fin_value;

	always_comb begin
		q_neg = total_q[TOT_W-1];
		if (!q_neg) begin
			q_sat = div_quo_q[DIV_BITS-1] ? {1'b0, {(DELTA_W-1){1'b1}}} : div_quo_q;
		end else if (div_quo_q > {1'b1, {(DIV_BITS-1){1'b0}}}) begin
			q_sat = {1'b1, {(DELTA_W-1){1'b0}}};
		end else begin
			q_sat = -div_quo_q;
		end
		rem_fin = q_neg ? -$signed({1'b0, div_rem_q}) : $signed({1'b0, div_rem_q});
		if (it_other_q) begin
			fin_kind  = KIND_PASS;
			fin_value = it_delta_q;
		end else begin
			case (it_role_q)
				ROLE_MOVE: begin
					fin_kind  = KIND_MOTION;
					fin_value = q_sat;
				end
				ROLE_SCROLL: begin
					fin_kind  = KIND_WHEEL;
					fin_value = q_sat;
				end
				ROLE_OFF: begin
					fin_kind  = KIND_MOTION;
					fin_value = '0;
				end
				ROLE_ENCODER: begin
					fin_kind  = KIND_CONSUMED;
					fin_value = '0;
				end
				default: begin
					fin_kind  = KIND_PASS;
					fin_value = it_delta_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_x_q <= ROLE_MOVE;
			role_y_q <= ROLE_MOVE;
			inv_x_q  <= 1'b0;
			inv_y_q  <= 1'b0;
			step_x_q <= STEP_W'(1);
			step_y_q <= STEP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROLE_X: role_x_q <= cfg_data[ROLE_W-1:0];
				CFG_ROLE_Y: role_y_q <= cfg_data[ROLE_W-1:0];
				CFG_INV_X:  inv_x_q  <= cfg_data[0];
				CFG_INV_Y:  inv_y_q  <= cfg_data[0];
				CFG_STEP_X: step_x_q <= cfg_data[STEP_W-1:0];
				CFG_STEP_Y: step_y_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			seen_x_q <= '0;
			seen_y_q <= '0;
		end else if (cmd.accept && !is_other) begin
			if (is_x) begin
				seen_x_q <= role_sel;
				if (changed) begin
					rem_x_q <= '0;
					acc_x_q <= '0;
				end
			end else begin
				seen_y_q <= role_sel;
				if (changed) begin
					rem_y_q <= '0;
					acc_y_q <= '0;
				end
			end
		end else if (cmd.emit_final && !it_other_q) begin
			if (it_role_q inside {ROLE_MOVE, ROLE_SCROLL}) begin
				if (it_axis_q == AXIS_X) rem_x_q <= rem_fin;
				else rem_y_q <= rem_fin;
			end else if (it_role_q == ROLE_ENCODER) begin
				if (it_axis_q == AXIS_X) acc_x_q <= acc_fin;
				else acc_y_q <= acc_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			it_axis_q  <= is_other ? AXIS_OTHER : in_axis_code;
			it_other_q <= is_other;
			it_role_q  <= role_sel;
			it_step_q  <= step_eff;
			it_delta_q <= in_delta;
			total_q    <= total_in;
			div_quo_q  <= total_mag[DIV_BITS-1:0];
			div_rem_q  <= '0;
			div_cnt_q  <= '0;
			tap_cnt_q  <= '0;
		end else begin
			if (cmd.div_step) begin
				div_quo_q <= {div_quo_q[DIV_BITS-2:0], div_ge};
				div_rem_q <= div_nxt;
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.emit_tap) begin
				total_q   <= tap_pos ? total_q - step_s : total_q + step_s;
				tap_cnt_q <= tap_cnt_q + TAP_CNT_W'(1);
			end
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_tap || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_tap) begin
			out_kind_q  <= KIND_TAP;
			out_axis_q  <= it_axis_q;
			out_value_q <= '0;
			out_neg_q   <= !tap_pos;
			out_last_q  <= 1'b0;
		end else if (cmd.emit_final) begin
			out_kind_q  <= fin_kind;
			out_axis_q  <= it_axis_q;
			out_value_q <= fin_value;
			out_neg_q   <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_axis         = out_axis_q;
	assign out_value        = out_value_q;
	assign out_tap_negative = out_neg_q;
	assign out_last         = out_last_q;

	assign sts.path      = path;
	assign sts.div_done  = (div_cnt_q == DIV_CNT_W'(DIV_BITS - 1));
	assign sts.tap_avail = tap_pos || tap_neg;
	assign sts.out_free  = out_free;

endmodule

`default_nettype wire

// ----- hw/rtl/pointer_axis_role_processor_top.sv -----
// Pointer axis role processor.
// pointer: one request per relative event (axis_code, delta). result: one or
// more results per request, the final one flagged by last.
// cfg_we/cfg_index/cfg_data write the role, invert and step registers; write
// only while no request is in flight.
// One request is worked at a time; pointer.ready is high only when idle.
// Work per request:
//   other axis, off and pass roles: a single result
//   move and scroll: the 16-step restoring divider
//     (one quotient bit per cycle)
//   encoder: up to MAX_TAPS taps, one tap per cycle unless the receiver stalls
// A result sits in an output register; the next request can be accepted
// while it waits. A stalled receiver holds the result and stops the
// sequencer at its next emit.
// Reset clears configuration to roles 0, inverts 0, steps 1, and clears the
// per-axis remainders, accumulators and seen roles.
`default_nettype none

module pointer_axis_role_processor_top import parp_pkg::*; #(
	parameter int unsigned MAX_TAPS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	parp_in_if.sink                    pointer,
	parp_out_if.source                 result
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	parp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pointer.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	parp_dp #(
		.MAX_TAPS (MAX_TAPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_axis_code     (pointer.axis_code),
		.in_delta         (pointer.delta),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_kind         (result.kind),
		.out_axis         (result.out_axis),
		.out_value        (result.out_value),
		.out_tap_negative (result.tap_negative),
		.out_last         (result.last),
		.cmd              (cmd),
		.sts              (sts)
	);

	assign pointer.ready = in_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/parp_chk.sv -----
`default_nettype none

module parp_chk import parp_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [KIND_W-1:0]         res_kind,
	input wire logic [AXIS_W-1:0]         res_axis,
	input wire logic signed [DELTA_W-1:0] res_value,
	input wire logic                      res_neg,
	input wire logic                      res_last
);

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another was in flight");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_axis)
			&& $stable(res_value) && $stable(res_neg) && $stable(res_last))
		else $error("stalled result changed");

	a_tap_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_TAP |-> !res_last && res_value == '0)
		else $error("tap result flagged last or nonzero");

	a_neg_only_tap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_TAP |-> !res_neg && res_last)
		else $error("non-tap result with tap flag or not last");

	a_consumed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_CONSUMED |-> res_value == '0 && res_axis != AXIS_OTHER)
		else $error("consumed result malformed");

endmodule

bind pointer_axis_role_processor_top parp_chk u_parp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pointer.valid),
	.in_ready  (pointer.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.kind),
	.res_axis  (result.out_axis),
	.res_value (result.out_value),
	.res_neg   (result.tap_negative),
	.res_last  (result.last)
);

`default_nettype wire
